>>> sv/stmm_pkg.sv
// ----------------------------------------------------------------------------
// stmm_pkg: shared constants for the sparse triplet matrix multiply block
// Default sizes and the func codes of an input item.
// ----------------------------------------------------------------------------
package stmm_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int MAX_OUT_DEF     = 32;
    localparam int INDEX_BITS_DEF  = 8;

    // func codes of an input item
    localparam logic [1:0] FUNC_LOAD_A  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_BT = 2'd1;
    localparam logic [1:0] FUNC_COMPUTE = 2'd2;

endpackage

>>> sv/sparse_triplet_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_multiply_top: sparse product of A and B in triplet form
// Loads triples of A and B-transposed into two tables, then merges row runs
// on column index with one shared multiply-accumulate and emits product terms.
// ----------------------------------------------------------------------------
// Load items are accepted back to back. A compute item runs each merge step
// as a table read, then compare and multiply; a pair-end step follows each
// pair of row runs and a final step closes the run, both of which can wait
// on result_stall. Each term is held until the next one is known or the run
// ends, then goes out through the output register; the last is marked.
// Reset clears counts, flags and the sequencer; table contents stay undefined.
// ----------------------------------------------------------------------------
module sparse_triplet_matrix_multiply_top
    import stmm_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_OUT     = MAX_OUT_DEF,
    parameter int INDEX_BITS  = INDEX_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               item_valid,
    output logic               item_stall,
    input  logic [1:0]         func,
    input  logic [7:0]         row_index,
    input  logic [7:0]         col_index,
    input  logic signed [15:0] value,

    output logic               result_valid,
    input  logic               result_stall,
    output logic [7:0]         out_row,
    output logic [7:0]         out_col,
    output logic signed [31:0] out_value,
    output logic               term_valid,
    output logic               overflow,
    output logic               last
);

    // Derived sizes
    localparam int IB           = INDEX_BITS;
    localparam int AW           = $clog2(TABLE_DEPTH);
    localparam int CW           = $clog2(TABLE_DEPTH + 1);
    localparam int RESULT_LIMIT = (MAX_OUT < 32) ? MAX_OUT : 32;
    localparam int NW           = $clog2(RESULT_LIMIT + 1);
    // |product| <= 2^30, at most TABLE_DEPTH products per pair, plus sign
    localparam int ACC_W        = 33 + $clog2(TABLE_DEPTH);
    localparam int EW           = 2 * IB + 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EX,
        ST_PAIR_END,
        ST_FINISH
    } state_t;

    // Table storage: {row, col, value} per entry
    logic [EW-1:0] a_mem  [TABLE_DEPTH];
    logic [EW-1:0] bt_mem [TABLE_DEPTH];

    state_t state_reg, state_next;
    logic [CW-1:0] a_cnt_reg, a_cnt_next;
    logic [CW-1:0] b_cnt_reg, b_cnt_next;
    logic          lovf_reg, lovf_next;
    logic [CW-1:0] ia_reg, ia_next;       // start of current A run
    logic [CW-1:0] ib_reg, ib_next;       // start of current BT run
    logic [CW-1:0] i_reg, i_next;         // merge pointer into A
    logic [CW-1:0] j_reg, j_next;         // merge pointer into BT
    logic          first_reg, first_next;
    logic [IB-1:0] a_row_reg, a_row_next;
    logic [IB-1:0] b_row_reg, b_row_next;
    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic signed [31:0] prod_reg, prod_next;
    logic          prod_vld_reg, prod_vld_next;
    logic [NW-1:0] n_reg, n_next;
    logic          ovf_reg, ovf_next;

    // Held term: sent once the next term shows up or the run ends
    logic          hold_vld_reg, hold_vld_next;
    logic [7:0]    hold_row_reg, hold_row_next;
    logic [7:0]    hold_col_reg, hold_col_next;
    logic [31:0]   hold_val_reg, hold_val_next;

    // Output register
    logic          out_vld_reg, out_vld_next;
    logic [7:0]    out_row_reg, out_row_next;
    logic [7:0]    out_col_reg, out_col_next;
    logic [31:0]   out_val_reg, out_val_next;
    logic          out_term_reg, out_term_next;
    logic          out_ovf_reg, out_ovf_next;
    logic          out_last_reg, out_last_next;

    // Table read data, registered
    logic [IB-1:0]      a_rd_row_reg, a_rd_col_reg;
    logic signed [15:0] a_rd_val_reg;
    logic [IB-1:0]      b_rd_row_reg, b_rd_col_reg;
    logic signed [15:0] b_rd_val_reg;

    // Load path
    logic          item_accept;
    logic          a_we, b_we;
    logic [IB+7:0] row_ext, col_ext;
    logic [EW-1:0] wr_word;

    // Merge step
    logic [IB-1:0]      a_row_cur, b_row_cur;
    logic               a_in, b_in;
    logic signed [31:0] mul;

    // Pair result
    logic               sum_nz;
    logic               sat_hi, sat_lo;
    logic [31:0]        sum_sat;
    logic [IB+7:0]      a_row_ext, b_row_ext;
    logic               out_free;
    logic               room;

    assign item_accept = item_valid && !item_stall;
    assign item_stall  = (state_reg != ST_IDLE);
    assign out_free    = !out_vld_reg || !result_stall;

    // low INDEX_BITS of the 8-bit index fields are kept
    assign row_ext = {{IB{1'b0}}, row_index};
    assign col_ext = {{IB{1'b0}}, col_index};
    assign wr_word = {row_ext[IB-1:0], col_ext[IB-1:0], value};

    assign a_row_cur = first_reg ? a_rd_row_reg : a_row_reg;
    assign b_row_cur = first_reg ? b_rd_row_reg : b_row_reg;
    assign a_in      = (i_reg < a_cnt_reg) && (a_rd_row_reg == a_row_cur);
    assign b_in      = (j_reg < b_cnt_reg) && (b_rd_row_reg == b_row_cur);
    assign mul       = 32'(a_rd_val_reg) * 32'(b_rd_val_reg);

    assign sum_nz  = (acc_reg != '0);
    assign sat_hi  = !acc_reg[ACC_W-1] && (|acc_reg[ACC_W-2:31]);
    assign sat_lo  = acc_reg[ACC_W-1] && !(&acc_reg[ACC_W-2:31]);
    assign sum_sat = sat_hi ? 32'h7FFF_FFFF :
                     sat_lo ? 32'h8000_0000 : acc_reg[31:0];
    assign a_row_ext = {8'd0, a_row_reg};
    assign b_row_ext = {8'd0, b_row_reg};
    assign room      = (n_reg < NW'(RESULT_LIMIT));

    always_comb
    begin
        state_next    = state_reg;
        a_cnt_next    = a_cnt_reg;
        b_cnt_next    = b_cnt_reg;
        lovf_next     = lovf_reg;
        ia_next       = ia_reg;
        ib_next       = ib_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        first_next    = first_reg;
        a_row_next    = a_row_reg;
        b_row_next    = b_row_reg;
        acc_next      = prod_vld_reg ? acc_reg + ACC_W'(prod_reg) : acc_reg;
        prod_next     = prod_reg;
        prod_vld_next = 1'b0;
        n_next        = n_reg;
        ovf_next      = ovf_reg;
        hold_vld_next = hold_vld_reg;
        hold_row_next = hold_row_reg;
        hold_col_next = hold_col_reg;
        hold_val_next = hold_val_reg;
        out_vld_next  = out_vld_reg && result_stall;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_val_next  = out_val_reg;
        out_term_next = out_term_reg;
        out_ovf_next  = out_ovf_reg;
        out_last_next = out_last_reg;
        a_we          = 1'b0;
        b_we          = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_accept)
                begin
                    case (func)
                        FUNC_LOAD_A:
                        begin
                            if (a_cnt_reg == CW'(TABLE_DEPTH))
                                lovf_next = 1'b1;
                            else
                            begin
                                a_we       = 1'b1;
                                a_cnt_next = a_cnt_reg + 1'b1;
                            end
                        end
                        FUNC_LOAD_BT:
                        begin
                            if (b_cnt_reg == CW'(TABLE_DEPTH))
                                lovf_next = 1'b1;
                            else
                            begin
                                b_we       = 1'b1;
                                b_cnt_next = b_cnt_reg + 1'b1;
                            end
                        end
                        FUNC_COMPUTE:
                        begin
                            ovf_next      = lovf_reg;
                            n_next        = '0;
                            hold_vld_next = 1'b0;
                            ia_next       = '0;
                            ib_next       = '0;
                            i_next        = '0;
                            j_next        = '0;
                            first_next    = 1'b1;
                            acc_next      = '0;
                            if (a_cnt_reg == '0 || b_cnt_reg == '0)
                                state_next = ST_FINISH;
                            else
                                state_next = ST_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RD:
            begin
                state_next = ST_EX;
            end

            ST_EX:
            begin
                a_row_next = a_row_cur;
                b_row_next = b_row_cur;
                first_next = 1'b0;
                state_next = ST_RD;
                if (a_in && b_in)
                begin
                    if (a_rd_col_reg < b_rd_col_reg)
                        i_next = i_reg + 1'b1;
                    else if (a_rd_col_reg > b_rd_col_reg)
                        j_next = j_reg + 1'b1;
                    else
                    begin
                        prod_next     = mul;
                        prod_vld_next = 1'b1;
                        i_next        = i_reg + 1'b1;
                        j_next        = j_reg + 1'b1;
                    end
                end
                else if (a_in)
                    i_next = i_reg + 1'b1;
                else if (b_in)
                    j_next = j_reg + 1'b1;
                else
                    state_next = ST_PAIR_END;   // i, j now at both run ends
            end

            ST_PAIR_END:
            begin
                if (!(sum_nz && room && hold_vld_reg && !out_free))
                begin
                    if (sum_nz)
                    begin
                        if (room)
                        begin
                            if (hold_vld_reg)
                            begin
                                out_vld_next  = 1'b1;
                                out_row_next  = hold_row_reg;
                                out_col_next  = hold_col_reg;
                                out_val_next  = hold_val_reg;
                                out_term_next = 1'b1;
                                out_ovf_next  = 1'b0;
                                out_last_next = 1'b0;
                            end
                            hold_vld_next = 1'b1;
                            hold_row_next = a_row_ext[7:0];
                            hold_col_next = b_row_ext[7:0];
                            hold_val_next = sum_sat;
                            n_next        = n_reg + 1'b1;
                        end
                        else
                            ovf_next = 1'b1;
                    end
                    acc_next   = '0;
                    first_next = 1'b1;
                    if (j_reg < b_cnt_reg)
                    begin
                        // next BT run against the same A run
                        ib_next    = j_reg;
                        i_next     = ia_reg;
                        state_next = ST_RD;
                    end
                    else if (i_reg < a_cnt_reg)
                    begin
                        // next A run, BT from the top
                        ia_next    = i_reg;
                        ib_next    = '0;
                        j_next     = '0;
                        state_next = ST_RD;
                    end
                    else
                        state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_vld_next  = 1'b1;
                    out_row_next  = hold_vld_reg ? hold_row_reg : 8'd0;
                    out_col_next  = hold_vld_reg ? hold_col_reg : 8'd0;
                    out_val_next  = hold_vld_reg ? hold_val_reg : 32'd0;
                    out_term_next = hold_vld_reg;
                    out_ovf_next  = ovf_reg;
                    out_last_next = 1'b1;
                    hold_vld_next = 1'b0;
                    a_cnt_next    = '0;
                    b_cnt_next    = '0;
                    lovf_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            a_cnt_reg    <= '0;
            b_cnt_reg    <= '0;
            lovf_reg     <= 1'b0;
            ia_reg       <= '0;
            ib_reg       <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            first_reg    <= 1'b0;
            prod_vld_reg <= 1'b0;
            n_reg        <= '0;
            ovf_reg      <= 1'b0;
            hold_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            a_cnt_reg    <= a_cnt_next;
            b_cnt_reg    <= b_cnt_next;
            lovf_reg     <= lovf_next;
            ia_reg       <= ia_next;
            ib_reg       <= ib_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            first_reg    <= first_next;
            prod_vld_reg <= prod_vld_next;
            n_reg        <= n_next;
            ovf_reg      <= ovf_next;
            hold_vld_reg <= hold_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        a_row_reg    <= a_row_next;
        b_row_reg    <= b_row_next;
        acc_reg      <= acc_next;
        prod_reg     <= prod_next;
        hold_row_reg <= hold_row_next;
        hold_col_reg <= hold_col_next;
        hold_val_reg <= hold_val_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
        out_val_reg  <= out_val_next;
        out_term_reg <= out_term_next;
        out_ovf_reg  <= out_ovf_next;
        out_last_reg <= out_last_next;
    end

    // Tables: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (a_we)
            a_mem[a_cnt_reg[AW-1:0]] <= wr_word;
        {a_rd_row_reg, a_rd_col_reg, a_rd_val_reg} <= a_mem[i_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            bt_mem[b_cnt_reg[AW-1:0]] <= wr_word;
        {b_rd_row_reg, b_rd_col_reg, b_rd_val_reg} <= bt_mem[j_reg[AW-1:0]];
    end

    assign result_valid = out_vld_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign out_value    = out_val_reg;
    assign term_valid   = out_term_reg;
    assign overflow     = out_ovf_reg;
    assign last         = out_last_reg;

endmodule

>>> sv/stmm_checker.sv
// ----------------------------------------------------------------------------
// stmm_checker: port-level checks for the sparse triplet matrix multiply
// Watches the item and result channels of the top level over time.
// ----------------------------------------------------------------------------
module stmm_checker
    import stmm_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_stall,
    input logic [1:0]         func,
    input logic               result_valid,
    input logic               result_stall,
    input logic [7:0]         out_row,
    input logic [7:0]         out_col,
    input logic signed [31:0] out_value,
    input logic               term_valid,
    input logic               overflow,
    input logic               last
);

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_value)
            && $stable(out_row) && $stable(out_col) && $stable(last))
        else $error("stalled result changed");

    // overflow is reported only on the last result
    a_ovf_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> !overflow)
        else $error("overflow on a non-final result");

    // empty marker is the only result of its run and is all zero
    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !term_valid |-> last && out_value == 32'sd0
            && out_row == 8'd0 && out_col == 8'd0)
        else $error("malformed empty product marker");

    // compute item occupies the block
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && func == FUNC_COMPUTE |=> item_stall)
        else $error("input not stalled after compute item");

endmodule

bind sparse_triplet_matrix_multiply_top stmm_checker u_stmm_checker (.*);

>>> tb/sparse_triplet_matrix_multiply_top_test.sv
// ----------------------------------------------------------------------------
// sparse_triplet_matrix_multiply_top_test: self-checking bench for the block
// Loads triples of A and B-transposed, runs product computes and compares
// every emitted term against a predictor kept in step with the item stream.
// ----------------------------------------------------------------------------
module sparse_triplet_matrix_multiply_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    import stmm_pkg::*;

    // func 3 has no meaning in the block; it must be swallowed silently
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam int RANDOM_ITEMS   = 200;
    localparam int LONG_HOLD      = 300;    // receiver hold-off, cycles
    localparam int WATCHDOG_LIMIT = 20000;  // cycles with no handshake at all
    localparam int DRAIN_CYCLES   = 40;

    localparam longint SUM_MAX = 64'sd2147483647;
    localparam longint SUM_MIN = -64'sd2147483648;

    // one product term as it leaves the block
    typedef struct {
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [31:0] total;
        logic               term;
        logic               ovf;
        logic               fin;
    } product_t;

    // one stored nonzero of A or B-transposed
    typedef struct {
        logic [7:0]         row;
        logic [7:0]         col;
        logic signed [15:0] val;
    } entry_t;

    // one row of the directed table; want is used only when typed is set
    typedef struct {
        logic [1:0]         f;
        logic [7:0]         r;
        logic [7:0]         c;
        logic signed [15:0] v;
        bit                 typed;
        product_t           want;
    } stim_t;

    typedef enum {SEQ_SORTED, SEQ_UNSORTED, SEQ_MANY_TERMS, SEQ_FULL_TABLE} seq_kind_t;

    localparam product_t NO_TERM       = '{8'd0, 8'd0, 32'sd0, 1'b0, 1'b0, 1'b0};
    localparam product_t EMPTY_PRODUCT = '{8'd0, 8'd0, 32'sd0, 1'b0, 1'b0, 1'b1};

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid;
    logic               item_stall;
    logic [1:0]         func;
    logic [7:0]         row_index;
    logic [7:0]         col_index;
    logic signed [15:0] value;
    logic               result_valid;
    logic               result_stall;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic signed [31:0] out_value;
    logic               term_valid;
    logic               overflow;
    logic               last;

    sparse_triplet_matrix_multiply_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .func         (func),
        .row_index    (row_index),
        .col_index    (col_index),
        .value        (value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_value    (out_value),
        .term_valid   (term_valid),
        .overflow     (overflow),
        .last         (last)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor state: its own copy of both tables, fill counts and the
    // dropped-load flag. Table entries at or above the fill are never read.
    // ------------------------------------------------------------------
    entry_t   a_store  [TABLE_DEPTH_DEF];
    entry_t   bt_store [TABLE_DEPTH_DEF];
    int       a_fill = 0;
    int       bt_fill = 0;
    bit       dropped_load = 1'b0;

    product_t step_terms[$];        // terms caused by the item just accepted
    product_t pending_terms[$];     // terms still owed by the block, oldest first

    int       n_fail = 0;
    int       n_items = 0;
    int       n_computes = 0;
    int       n_terms_checked = 0;
    int       n_flagged = 0;
    int       quiet_cycles = 0;

    bit       tx_quiet = 1'b0;      // sender offers back to back
    bit       rx_quiet = 1'b0;      // receiver adds no random stall per result
    bit       rx_hold_req = 1'b0;   // receiver does one long hold-off

    // ------------------------------------------------------------------
    // Directed items: extremes, saturation both ways, zero sum, empty
    // product, the ignored func code and an out-of-order BT run.
    // ------------------------------------------------------------------
    stim_t dir_tab [26] = '{
        // compute with nothing loaded: empty product marker
        '{FUNC_COMPUTE, 8'd0,   8'd0,   16'sd0,      1'b1, EMPTY_PRODUCT},
        '{FUNC_NONE,    8'hA5,  8'h5A,  16'sh1234,   1'b0, NO_TERM},
        // top corner indices, min times min
        '{FUNC_LOAD_A,  8'd255, 8'd255, 16'sh8000,   1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'd255, 8'd255, 16'sh8000,   1'b0, NO_TERM},
        '{FUNC_COMPUTE, 8'd0,   8'd0,   16'sd0,      1'b1,
          '{8'd255, 8'd255, 32'sd1073741824, 1'b1, 1'b0, 1'b1}},
        // two min-by-min products: saturates high
        '{FUNC_LOAD_A,  8'd0,   8'd0,   16'sh8000,   1'b0, NO_TERM},
        '{FUNC_LOAD_A,  8'd0,   8'd1,   16'sh8000,   1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'd1,   8'd0,   16'sh8000,   1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'd1,   8'd1,   16'sh8000,   1'b0, NO_TERM},
        '{FUNC_COMPUTE, 8'hFF,  8'hFF,  16'shFFFF,   1'b1,
          '{8'd0, 8'd1, 32'sh7FFFFFFF, 1'b1, 1'b0, 1'b1}},
        // three min-by-max products: saturates low
        '{FUNC_LOAD_A,  8'd5,   8'd0,   16'sh8000,   1'b0, NO_TERM},
        '{FUNC_LOAD_A,  8'd5,   8'd1,   16'sh8000,   1'b0, NO_TERM},
        '{FUNC_LOAD_A,  8'd5,   8'd2,   16'sh8000,   1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'd7,   8'd0,   16'sh7FFF,   1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'd7,   8'd1,   16'sh7FFF,   1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'd7,   8'd2,   16'sh7FFF,   1'b0, NO_TERM},
        '{FUNC_COMPUTE, 8'd0,   8'd0,   16'sd0,      1'b1,
          '{8'd5, 8'd7, 32'sh80000000, 1'b1, 1'b0, 1'b1}},
        // products cancel: no term, so the empty marker comes out
        '{FUNC_LOAD_A,  8'd1,   8'd3,   16'sd2,      1'b0, NO_TERM},
        '{FUNC_LOAD_A,  8'd1,   8'd4,   16'sd3,      1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'd2,   8'd3,   16'sd3,      1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'd2,   8'd4,  -16'sd2,      1'b0, NO_TERM},
        '{FUNC_COMPUTE, 8'd0,   8'd0,   16'sd0,      1'b1, EMPTY_PRODUCT},
        // BT run with columns out of order, left to the predictor
        '{FUNC_LOAD_A,  8'h3C,  8'hC3,  16'sh00FF,   1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'hC3,  8'hC3,  16'sh0101,   1'b0, NO_TERM},
        '{FUNC_LOAD_BT, 8'hC3,  8'h3C,  16'sh5555,   1'b0, NO_TERM},
        '{FUNC_COMPUTE, 8'h00,  8'h00,  16'sh0000,   1'b0, NO_TERM}
    };

    // end index of the run of equal rows that starts at start
    function automatic int run_stop(input bit on_a, input int start);
        int j;
        int fill;
        fill = on_a ? a_fill : bt_fill;
        j = start;
        while (j < fill && (on_a ? a_store[j].row == a_store[start].row
                                 : bt_store[j].row == bt_store[start].row))
            j++;
        return j;
    endfunction

    // merge every A row run with every BT row run; fills step_terms
    function automatic void predict_product();
        int       ia, ea, ib, eb, i, j, n;
        longint   acc, av, bv;
        bit       ovf;
        product_t t;
        ovf = dropped_load;
        n = 0;
        ia = 0;
        while (ia < a_fill) begin
            ea = run_stop(1'b1, ia);
            ib = 0;
            while (ib < bt_fill) begin
                eb = run_stop(1'b0, ib);
                i = ia;
                j = ib;
                acc = 0;
                // advance the smaller column, both on a match
                while (i < ea && j < eb) begin
                    if (a_store[i].col < bt_store[j].col)
                        i++;
                    else if (a_store[i].col > bt_store[j].col)
                        j++;
                    else
                    begin
                        av = a_store[i].val;
                        bv = bt_store[j].val;
                        acc += av * bv;
                        i++;
                        j++;
                    end
                end
                if (acc != 0) begin
                    if (n < MAX_OUT_DEF) begin
                        t.row = a_store[ia].row;
                        t.col = bt_store[ib].row;
                        if (acc > SUM_MAX)
                            t.total = 32'sh7FFFFFFF;
                        else if (acc < SUM_MIN)
                            t.total = 32'sh80000000;
                        else
                            t.total = acc[31:0];
                        t.term = 1'b1;
                        t.ovf = 1'b0;
                        t.fin = 1'b0;
                        step_terms.push_back(t);
                        n++;
                    end
                    else
                        ovf = 1'b1;    // term beyond the output limit
                end
                ib = eb;
            end
            ia = ea;
        end
        if (n == 0)
            step_terms.push_back(EMPTY_PRODUCT);
        step_terms[step_terms.size() - 1].ovf = ovf;
        step_terms[step_terms.size() - 1].fin = 1'b1;
        if (ovf)
            n_flagged++;
        a_fill = 0;
        bt_fill = 0;
        dropped_load = 1'b0;
    endfunction

    function automatic void predict_item(input logic [1:0] f, input logic [7:0] r,
                                         input logic [7:0] c, input logic signed [15:0] v);
        step_terms.delete();
        case (f)
            FUNC_LOAD_A:
                if (a_fill >= TABLE_DEPTH_DEF)
                    dropped_load = 1'b1;
                else
                begin
                    a_store[a_fill] = '{r, c, v};
                    a_fill++;
                end
            FUNC_LOAD_BT:
                if (bt_fill >= TABLE_DEPTH_DEF)
                    dropped_load = 1'b1;
                else
                begin
                    bt_store[bt_fill] = '{r, c, v};
                    bt_fill++;
                end
            FUNC_COMPUTE:
            begin
                n_computes++;
                predict_product();
            end
            default: ;
        endcase
    endfunction

    function automatic logic signed [15:0] elem_value(input bit nonzero);
        logic signed [15:0] v;
        case ($urandom_range(0, 15))
            0:       v = 16'sh8000;
            1:       v = 16'sh7FFF;
            2:       v = 16'sd0;
            default: v = 16'($urandom);
        endcase
        if (nonzero && v == 0)
            v = 16'sd1;
        return v;
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endfunction

    // ------------------------------------------------------------------
    // Sender: random gap, then hold the item until the block takes it.
    // The predictor advances on the edge that accepts the item.
    // ------------------------------------------------------------------
    task automatic drive_item(input logic [1:0] f, input logic [7:0] r, input logic [7:0] c,
                              input logic signed [15:0] v, input bit typed,
                              input product_t want);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        func      <= f;
        row_index <= r;
        col_index <= c;
        value     <= v;
        @(posedge clk);
        while (item_stall !== 1'b0)
            @(posedge clk);
        predict_item(f, r, c, v);
        if (typed)
            pending_terms.push_back(want);
        else
            foreach (step_terms[k])
                pending_terms.push_back(step_terms[k]);
        if (f != FUNC_NONE)
            n_items++;
    endtask

    // sender stops offering until the block has delivered everything owed
    task automatic wait_for_drain();
        item_valid <= 1'b0;
        while (pending_terms.size() != 0)
            @(posedge clk);
    endtask

    // one load run for A and BT followed by a compute item
    task automatic run_product_sequence(input seq_kind_t kind);
        logic [15:0] a_keys[$];
        logic [15:0] bt_keys[$];
        logic [7:0]  rows[3];
        logic [7:0]  cols[4];
        logic [15:0] key;
        logic [1:0]  f;
        int          na, nb, base_a, base_b;
        bit          pick_a;
        foreach (rows[k])
            rows[k] = 8'($urandom);
        foreach (cols[k])
            cols[k] = 8'($urandom);
        na = $urandom_range(0, 6);
        nb = $urandom_range(0, 6);
        case (kind)
            SEQ_MANY_TERMS:
            begin
                // six distinct rows on each side sharing one column: 36 nonzero terms, over the limit of 32
                base_a = $urandom_range(0, 250);
                base_b = $urandom_range(0, 250);
                for (int k = 0; k < 6; k++) begin
                    a_keys.push_back({8'(base_a + k), cols[0]});
                    bt_keys.push_back({8'(base_b + k), cols[0]});
                end
            end
            SEQ_FULL_TABLE:
            begin
                // one table gets more loads than it can hold
                if ($urandom_range(0, 1)) begin
                    na = TABLE_DEPTH_DEF + 2;
                    nb = 3;
                end
                else
                begin
                    na = 3;
                    nb = TABLE_DEPTH_DEF + 2;
                end
            end
            default: ;
        endcase
        if (kind != SEQ_MANY_TERMS) begin
            for (int k = 0; k < na; k++)
                a_keys.push_back({rows[$urandom_range(0, 2)], cols[$urandom_range(0, 3)]});
            for (int k = 0; k < nb; k++)
                bt_keys.push_back({rows[$urandom_range(0, 2)], cols[$urandom_range(0, 3)]});
        end
        if (kind != SEQ_UNSORTED) begin
            a_keys.sort();
            bt_keys.sort();
        end
        // interleave the two tables, each in its own order
        while (a_keys.size() + bt_keys.size() > 0) begin
            if (kind == SEQ_UNSORTED && $urandom_range(0, 5) == 0)
                drive_item(FUNC_NONE, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0, NO_TERM);
            pick_a = (bt_keys.size() == 0) || (a_keys.size() != 0 && $urandom_range(0, 1) == 1);
            if (pick_a) begin
                key = a_keys.pop_front();
                f = FUNC_LOAD_A;
            end
            else
            begin
                key = bt_keys.pop_front();
                f = FUNC_LOAD_BT;
            end
            drive_item(f, key[15:8], key[7:0], elem_value(kind == SEQ_MANY_TERMS), 1'b0,
                       NO_TERM);
        end
        // the other fields of a compute item are don't-care; keep them moving
        drive_item(FUNC_COMPUTE, 8'($urandom), 8'($urandom), 16'($urandom), 1'b0, NO_TERM);
    endtask

    // ------------------------------------------------------------------
    // Main flow: reset, directed table, random product sequences, drain.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int        seq;
        int        random_start;
        seq_kind_t kind;
        item_valid <= 1'b0;
        func       <= FUNC_LOAD_A;
        row_index  <= 8'd0;
        col_index  <= 8'd0;
        value      <= 16'sd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[k])
            drive_item(dir_tab[k].f, dir_tab[k].r, dir_tab[k].c, dir_tab[k].v,
                       dir_tab[k].typed, dir_tab[k].want);

        random_start = n_items;
        seq = 0;
        while (n_items < random_start + RANDOM_ITEMS) begin
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if (seq == 2 || seq == 11)
                kind = SEQ_MANY_TERMS;
            else if (seq == 6)
                kind = SEQ_FULL_TABLE;
            else if ($urandom_range(0, 4) == 0)
                kind = SEQ_UNSORTED;
            else
                kind = SEQ_SORTED;
            // first big product: receiver backs off while loads keep coming,
            // so the block's output side fills and it stalls the input
            if (seq == 2) begin
                rx_hold_req = 1'b1;
                tx_quiet = 1'b1;
            end
            run_product_sequence(kind);
            if (seq % 4 == 3)
                wait_for_drain();
            seq++;
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d items in %0d product computes, %0d terms checked,",
                 n_items, n_computes, n_terms_checked);
        $display("%0d runs ended with the overflow flag set.", n_flagged);
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stall per result, one long hold-off on request.
    // Each accepted result is checked against the oldest pending term.
    // ------------------------------------------------------------------
    initial begin : result_side
        int       hold;
        product_t exp_t;
        result_stall <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            hold = rx_quiet ? 0 : $urandom_range(0, 14);
            if (hold > 0) begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            @(posedge clk);
            while (result_valid !== 1'b1)
                @(posedge clk);
            if (pending_terms.size() == 0) begin
                $error("result with nothing pending: row %0d col %0d value %0d",
                       out_row, out_col, out_value);
                n_fail++;
            end
            else
            begin
                exp_t = pending_terms.pop_front();
                check_field("out_row",    {24'd0, exp_t.row},  {24'd0, out_row});
                check_field("out_col",    {24'd0, exp_t.col},  {24'd0, out_col});
                check_field("out_value",  exp_t.total,         out_value);
                check_field("term_valid", {31'd0, exp_t.term}, {31'd0, term_valid});
                check_field("overflow",   {31'd0, exp_t.ovf},  {31'd0, overflow});
                check_field("last",       {31'd0, exp_t.fin},  {31'd0, last});
                n_terms_checked++;
            end
        end
    end

    // watchdog: a stretch with no handshake on either side that reaches WATCHDOG_LIMIT ends the run
    always @(posedge clk) begin
        if ((item_valid === 1'b1 && item_stall === 1'b0) ||
            (result_valid === 1'b1 && result_stall === 1'b0))
            quiet_cycles <= 0;
        else if (rst_n === 1'b1)
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $error("no handshake for %0d cycles, %0d terms pending",
                       quiet_cycles, pending_terms.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

>>> sparse_triplet_matrix_multiply_top.f
sv/stmm_pkg.sv
sv/sparse_triplet_matrix_multiply_top.sv
sv/stmm_checker.sv
tb/sparse_triplet_matrix_multiply_top_test.sv
